// ===== hdl/coc_pkg.sv =====
// Shared types, register codes and constants for the cursor overlay compositor.
package coc_pkg;

  localparam int unsigned SCREEN_WIDTH  = 640;
  localparam int unsigned SCREEN_HEIGHT = 480;
  localparam int unsigned CURSOR_SIZE   = 16;

  localparam int unsigned COORD_W  = 11;
  localparam int unsigned OFFSET_W = 8;
  localparam int unsigned POS_W    = 13;  // signed footprint arithmetic
  localparam int unsigned ROW_W    = 4;
  localparam int unsigned COL_W    = 4;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [PIX_W-1:0] PIX_BLACK = 32'h0000_0000;
  localparam logic [PIX_W-1:0] PIX_WHITE = 32'h00FF_FFFF;

  localparam logic [COORD_W-1:0]  CURSOR_X_RST   = 11'd320;
  localparam logic [COORD_W-1:0]  CURSOR_Y_RST   = 11'd240;
  localparam logic [OFFSET_W-1:0] HOT_OFFSET_RST = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_CURSOR_X = 3'd1,
    REG_CURSOR_Y = 3'd2,
    REG_HOT_X    = 3'd3,
    REG_HOT_Y    = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPOSE = 1'b1
  } op_t;

  typedef struct packed {
    logic                    enable;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
  } cfg_t;

  typedef struct packed {
    logic                    we;
    logic [ROW_W-1:0]        row;
    logic [CURSOR_SIZE-1:0]  set_bits;
    logic [CURSOR_SIZE-1:0]  clear_bits;
  } glyph_wr_t;

  localparam logic [CURSOR_SIZE-1:0] ARROW_SET [CURSOR_SIZE] = '{
    16'h0000, 16'h7FFE, 16'h7FFC, 16'h7FF0, 16'h7FE0, 16'h7FE0, 16'h7FF0, 16'h7FF8,
    16'h7FFC, 16'h7FFE, 16'h7FFC, 16'h73F8, 16'h61F0, 16'h60E0, 16'h4040, 16'h0000
  };
  localparam logic [CURSOR_SIZE-1:0] ARROW_CLEAR [CURSOR_SIZE] = '{
    16'hFFFF, 16'h8001, 16'h8002, 16'h800C, 16'h8010, 16'h8010, 16'h8008, 16'h8004,
    16'h8002, 16'h8001, 16'h8002, 16'h8C04, 16'h9208, 16'h9110, 16'hA0A0, 16'hC040
  };

endpackage

// ===== hdl/cursor_overlay_compositor.sv =====
// Cursor overlay compositor top level: four-stage pixel pipeline.
//
// Input channel (in_valid/in_ready) takes one item per transfer: op selects a
// glyph row load (glyph_row, set_bits, clear_bits) or a pixel compose
// (pixel_x, pixel_y, pixel_in). Loads give no output. Each compose gives one
// output transfer (out_valid/out_ready) with pixel_out and cursor_hit.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 enable,
// 1 cursor_x, 2 cursor_y, 3 hot_offset_x, 4 hot_offset_y); write only while
// the pipeline is empty.
// A compose result passes the input, footprint position, glyph row read and
// output stage registers before it is presented. Throughput: one item per
// cycle while the output is not stalled, set by the four stage registers
// (input, footprint position, glyph row read, output).
// A glyph load takes effect for every compose item that follows it.
// Reset: pipeline emptied, registers to their defaults, glyph to the arrow.
// Receiver stall: each stage holds while the next is full; bubbles close up,
// so up to three more compose items are taken before in_ready drops.
module cursor_overlay_compositor
  import coc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   op,
  input  logic [ROW_W-1:0]       glyph_row,
  input  logic [CURSOR_SIZE-1:0] set_bits,
  input  logic [CURSOR_SIZE-1:0] clear_bits,
  input  logic [COORD_W-1:0]     pixel_x,
  input  logic [COORD_W-1:0]     pixel_y,
  input  logic [PIX_W-1:0]       pixel_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIX_W-1:0]       pixel_out,
  output logic                   cursor_hit
);

  cfg_t cfg;

  // stage A: raw input
  logic                   va;
  logic                   a_op;
  logic [ROW_W-1:0]       a_row;
  logic [CURSOR_SIZE-1:0] a_set;
  logic [CURSOR_SIZE-1:0] a_clear;
  logic [COORD_W-1:0]     a_x;
  logic [COORD_W-1:0]     a_y;
  logic [PIX_W-1:0]       a_pix;

  // stage B: footprint position
  logic                    vb;
  logic                    b_op;
  logic [ROW_W-1:0]        b_row;
  logic [CURSOR_SIZE-1:0]  b_set;
  logic [CURSOR_SIZE-1:0]  b_clear;
  logic signed [POS_W-1:0] b_col;
  logic signed [POS_W-1:0] b_line;
  logic                    b_onscreen;
  logic [PIX_W-1:0]        b_pix;

  // stage C: glyph row
  logic               vc;
  logic               c_inside;
  logic [COL_W-1:0]   c_col;
  logic [PIX_W-1:0]   c_pix;
  logic [CURSOR_SIZE-1:0] c_set;
  logic [CURSOR_SIZE-1:0] c_clear;

  logic vd;
  logic en_a, en_b, en_c, en_d;
  logic b_inside;
  glyph_wr_t glyph_wr;

  coc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign en_d     = !vd || out_ready;
  assign en_c     = !vc || en_d;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb && (op_t'(b_op) == OP_COMPOSE);
      if (en_d) vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_op    <= op;
      a_row   <= glyph_row;
      a_set   <= set_bits;
      a_clear <= clear_bits;
      a_x     <= pixel_x;
      a_y     <= pixel_y;
      a_pix   <= pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      b_op       <= a_op;
      b_row      <= a_row;
      b_set      <= a_set;
      b_clear    <= a_clear;
      b_col      <= $signed({2'b00, a_x}) - cfg.origin_x;
      b_line     <= $signed({2'b00, a_y}) - cfg.origin_y;
      b_onscreen <= ({1'b0, a_x} < (COORD_W+1)'(SCREEN_WIDTH))
                 && ({1'b0, a_y} < (COORD_W+1)'(SCREEN_HEIGHT));
      b_pix      <= a_pix;
    end
  end

  assign b_inside = cfg.enable && b_onscreen
                 && (b_col[POS_W-1:COL_W] == '0) && (b_line[POS_W-1:ROW_W] == '0);

  always_comb begin
    glyph_wr.we         = vb && en_c && (op_t'(b_op) == OP_LOAD);
    glyph_wr.row        = b_row;
    glyph_wr.set_bits   = b_set;
    glyph_wr.clear_bits = b_clear;
  end

  coc_glyph u_glyph (
    .clk     (clk),
    .rst     (rst),
    .wr      (glyph_wr),
    .rd_en   (en_c),
    .rd_row  (b_line[ROW_W-1:0]),
    .set_q   (c_set),
    .clear_q (c_clear)
  );

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_inside <= b_inside;
      c_col    <= b_col[COL_W-1:0];
      c_pix    <= b_pix;
    end
  end

  coc_pix u_pix (
    .clk        (clk),
    .en         (en_d),
    .covered    (c_inside),
    .col        (c_col),
    .set_row    (c_set),
    .clear_row  (c_clear),
    .pix        (c_pix),
    .pixel_out  (pixel_out),
    .cursor_hit (cursor_hit)
  );

  assign out_valid = vd;

`ifndef SYNTH
  a_hit_colour: assert property (@(posedge clk) disable iff (rst)
    out_valid && cursor_hit |-> (pixel_out == PIX_BLACK || pixel_out == PIX_WHITE))
    else $error("cursor hit with a pixel that is neither black nor white");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output stage empty");
`endif

endmodule

// ===== hdl/coc_cfg.sv =====
// Configuration registers and glyph origin for the cursor overlay compositor.
module coc_cfg
  import coc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic                cursor_enable;
  logic [COORD_W-1:0]  cursor_x;
  logic [COORD_W-1:0]  cursor_y;
  logic [OFFSET_W-1:0] hot_offset_x;
  logic [OFFSET_W-1:0] hot_offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_enable <= 1'b0;
      cursor_x      <= CURSOR_X_RST;
      cursor_y      <= CURSOR_Y_RST;
      hot_offset_x  <= HOT_OFFSET_RST;
      hot_offset_y  <= HOT_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ENABLE:   cursor_enable <= cfg_data[0];
        REG_CURSOR_X: cursor_x      <= cfg_data[COORD_W-1:0];
        REG_CURSOR_Y: cursor_y      <= cfg_data[COORD_W-1:0];
        REG_HOT_X:    hot_offset_x  <= cfg_data[OFFSET_W-1:0];
        REG_HOT_Y:    hot_offset_y  <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.enable   = cursor_enable;
    cfg.origin_x = $signed({2'b00, cursor_x})
                 + $signed({{(POS_W-OFFSET_W){hot_offset_x[OFFSET_W-1]}}, hot_offset_x});
    cfg.origin_y = $signed({2'b00, cursor_y})
                 + $signed({{(POS_W-OFFSET_W){hot_offset_y[OFFSET_W-1]}}, hot_offset_y});
  end

endmodule

// ===== hdl/coc_glyph.sv =====
// Two-plane glyph store: one row written per load, one row read per compose.
module coc_glyph
  import coc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  glyph_wr_t              wr,
  input  logic                   rd_en,
  input  logic [ROW_W-1:0]       rd_row,
  output logic [CURSOR_SIZE-1:0] set_q,
  output logic [CURSOR_SIZE-1:0] clear_q
);

  logic [CURSOR_SIZE-1:0] set_rows   [CURSOR_SIZE];
  logic [CURSOR_SIZE-1:0] clear_rows [CURSOR_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CURSOR_SIZE; i++) begin
        set_rows[i]   <= ARROW_SET[i];
        clear_rows[i] <= ARROW_CLEAR[i];
      end
    end else if (wr.we) begin
      set_rows[wr.row]   <= wr.set_bits;
      clear_rows[wr.row] <= wr.clear_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      set_q   <= set_rows[rd_row];
      clear_q <= clear_rows[rd_row];
    end
  end

endmodule

// ===== hdl/coc_pix.sv =====
// Final stage: picks the glyph column bit and forms the composed pixel.
module coc_pix
  import coc_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic                   covered,
  input  logic [COL_W-1:0]       col,
  input  logic [CURSOR_SIZE-1:0] set_row,
  input  logic [CURSOR_SIZE-1:0] clear_row,
  input  logic [PIX_W-1:0]       pix,
  output logic [PIX_W-1:0]       pixel_out,
  output logic                   cursor_hit
);

  logic             set_bit;
  logic             clear_bit;
  logic [PIX_W-1:0] pixel_next;
  logic             hit_next;

  always_comb begin
    // MSB is the leftmost column
    set_bit   = set_row[~col];
    clear_bit = clear_row[~col];
    hit_next  = covered && (set_bit || clear_bit);
    if (covered && set_bit)
      pixel_next = PIX_BLACK;
    else if (covered && clear_bit)
      pixel_next = PIX_WHITE;
    else
      pixel_next = pix;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pixel_out  <= pixel_next;
      cursor_hit <= hit_next;
    end
  end

endmodule
